// ----- src/itnp_pkg.sv -----
// shared widths, constants and types of the text number parser
package itnp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CHAR_WIDTH  = 8;
    localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
    localparam int HEX_CNT_W   = $clog2(HEX_DIGITS + 2);
    localparam int PROD_WIDTH  = VALUE_WIDTH + 4;
    localparam int CFG_IDX_W   = 1;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [CHAR_WIDTH-1:0]  char_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
    typedef logic [HEX_CNT_W-1:0]   hex_cnt_t;
    typedef logic [PROD_WIDTH-1:0]  prod_t;

    localparam cfg_idx_t REG_MIN_ALLOWED = CFG_IDX_W'(0);
    localparam cfg_idx_t REG_MAX_ALLOWED = CFG_IDX_W'(1);

    localparam value_t INT_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam value_t INT_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_LF    = 8'h0a;
    localparam char_t CH_CR    = 8'h0d;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_MINUS = 8'h2d;
    localparam char_t CH_0     = 8'h30;
    localparam char_t CH_1     = 8'h31;
    localparam char_t CH_9     = 8'h39;
    localparam char_t CH_UA    = 8'h41;
    localparam char_t CH_UF    = 8'h46;
    localparam char_t CH_UX    = 8'h58;
    localparam char_t CH_LA    = 8'h61;
    localparam char_t CH_LF_HEX = 8'h66;
    localparam char_t CH_LX    = 8'h78;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_ZERO = 5'b00010,
        PH_DEC  = 5'b00100,
        PH_HEX  = 5'b01000,
        PH_SKIP = 5'b10000
    } phase_t;

endpackage

// ----- src/itnp_char_if.sv -----
// request channel carrying one text byte
interface itnp_char_if import itnp_pkg::*; ();
    logic  valid;
    logic  ready;
    char_t ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

// ----- src/itnp_result_if.sv -----
// request channel carrying one parse result
interface itnp_result_if import itnp_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t value;
    logic   valid_res;

    modport source (output valid, output value, output valid_res, input ready);
    modport sink (input valid, input value, input valid_res, output ready);
endinterface

// ----- src/itnp_cfg_if.sv -----
// register write channel
interface itnp_cfg_if import itnp_pkg::*; ();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    value_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/int32_text_number_parser_top.sv -----
// streaming decimal/hex text to signed integer parser
//
// text: one byte per request; leading space, tab, CR and LF are skipped, a
// token ends at one of those or at NUL and the ending byte belongs to it.
// tokens starting 0x/0X are hex (up to 8 digits, raw 32-bit pattern), others
// are decimal with an optional leading minus and signed overflow checks.
// result: one request per token, value plus valid_res; value is 0 on a parse
// error or when outside [min_allowed, max_allowed].
// cfg: index 0 writes min_allowed, index 1 writes max_allowed; always ready,
// write only while no token is in progress and the result is delivered.
// throughput: one byte per cycle unless a result stalls, set by the single per-byte state update.
// the result request is valid in the cycle after the ending byte is taken.
// stall: the result sits in an output register; text stays ready while that
// register is empty or being drained, so a stalled receiver holds the text
// side after at most one pending result.
// reset: bounds go to the full signed range, the parser returns to idle and
// the output register empties.
module int32_text_number_parser_top import itnp_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    itnp_char_if.sink     text,
    itnp_result_if.source result,
    itnp_cfg_if.sink      cfg
);

    phase_t   phase_reg, phase_next;
    value_t   accum_reg, accum_next;
    logic     negative_reg, negative_next;
    hex_cnt_t hex_cnt_reg, hex_cnt_next;
    value_t   min_reg, max_reg;
    logic     out_valid_reg;
    value_t   out_value_reg;
    logic     out_ok_reg;

    logic     in_fire;
    logic     is_delim;
    logic     is_dec;
    logic     is_hex;
    value_t   digit;
    prod_t    prod;
    prod_t    limit;
    logic     dec_ovf;
    hex_cnt_t hex_cnt_inc;
    logic     emit;
    logic     emit_ok;
    value_t   emit_pat;
    logic     in_range;

    assign text.ready = !out_valid_reg || result.ready;
    assign in_fire    = text.valid && text.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid     = out_valid_reg;
    assign result.value     = out_value_reg;
    assign result.valid_res = out_ok_reg;

    always_comb
    begin
        is_delim = (text.ch inside {CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF});
        is_dec   = (text.ch inside {[CH_0:CH_9]});
        is_hex   = 1'b1;
        digit    = '0;
        if (text.ch inside {[CH_0:CH_9]})
        begin
            digit = VALUE_WIDTH'(text.ch - CH_0);
        end
        else if (text.ch inside {[CH_LA:CH_LF_HEX]})
        begin
            digit = VALUE_WIDTH'(text.ch - CH_LA + 8'd10);
        end
        else if (text.ch inside {[CH_UA:CH_UF]})
        begin
            digit = VALUE_WIDTH'(text.ch - CH_UA + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // accum * 10 + digit against the signed limit
    assign prod  = (PROD_WIDTH'(accum_reg) << 3) + (PROD_WIDTH'(accum_reg) << 1)
                 + PROD_WIDTH'(digit);
    assign limit = negative_reg ? PROD_WIDTH'(INT_MIN) : PROD_WIDTH'(INT_MAX);
    assign dec_ovf = prod > limit;
    assign hex_cnt_inc = hex_cnt_reg + hex_cnt_t'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        negative_next = negative_reg;
        hex_cnt_next  = hex_cnt_reg;
        emit          = 1'b0;
        emit_ok       = 1'b0;
        emit_pat      = '0;
        case (phase_reg)
            PH_ZERO:
            begin
                if (is_delim)
                begin
                    emit    = 1'b1;
                    emit_ok = 1'b1;
                end
                else if (text.ch == CH_LX || text.ch == CH_UX)
                begin
                    phase_next   = PH_HEX;
                    accum_next   = '0;
                    hex_cnt_next = '0;
                end
                else if (is_dec && !dec_ovf)
                begin
                    phase_next = PH_DEC;
                    accum_next = prod[VALUE_WIDTH-1:0];
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_DEC:
            begin
                if (is_delim)
                begin
                    emit     = 1'b1;
                    emit_ok  = 1'b1;
                    emit_pat = negative_reg ? (value_t'(0) - accum_reg) : accum_reg;
                end
                else if (is_dec && !dec_ovf)
                begin
                    accum_next = prod[VALUE_WIDTH-1:0];
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_HEX:
            begin
                if (is_delim)
                begin
                    emit     = 1'b1;
                    emit_ok  = 1'b1;
                    emit_pat = accum_reg;
                end
                else if (!is_hex)
                begin
                    phase_next = PH_SKIP;
                end
                else
                begin
                    accum_next   = (accum_reg << 4) | digit;
                    hex_cnt_next = hex_cnt_inc;
                    if (hex_cnt_inc > hex_cnt_t'(HEX_DIGITS))
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (is_delim)
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (text.ch == CH_NUL)
                begin
                    emit    = 1'b1;
                    emit_ok = 1'b1;
                end
                else if (!is_delim)
                begin
                    accum_next    = '0;
                    negative_next = 1'b0;
                    hex_cnt_next  = '0;
                    if (text.ch == CH_0)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else if (text.ch == CH_MINUS)
                    begin
                        negative_next = 1'b1;
                        phase_next    = PH_DEC;
                    end
                    else if (text.ch inside {[CH_1:CH_9]})
                    begin
                        accum_next = digit;
                        phase_next = PH_DEC;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
        endcase
        if (emit)
        begin
            phase_next    = PH_IDLE;
            accum_next    = '0;
            negative_next = 1'b0;
            hex_cnt_next  = '0;
        end
    end

    assign in_range = ($signed(emit_pat) >= $signed(min_reg))
                   && ($signed(emit_pat) <= $signed(max_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            accum_reg    <= '0;
            negative_reg <= 1'b0;
            hex_cnt_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            negative_reg <= negative_next;
            hex_cnt_reg  <= hex_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= INT_MIN;
            max_reg <= INT_MAX;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_MIN_ALLOWED: min_reg <= cfg.data;
                REG_MAX_ALLOWED: max_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            out_ok_reg    <= emit_ok && in_range;
            out_value_reg <= (emit_ok && in_range) ? emit_pat : '0;
        end
    end

endmodule

// ----- src/itnp_checker.sv -----
// port-level checks of the parser, bound to the top level
module itnp_checker import itnp_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input value_t out_value,
    input logic   out_ok
);

    // a pending result blocks new bytes only while the receiver stalls
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("text accepted while result stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("text not ready with empty output");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ok) |-> (out_value == '0))
        else $error("failed result with nonzero value");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without a text request");

endmodule

bind int32_text_number_parser_top itnp_checker u_itnp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.value),
    .out_ok    (result.valid_res)
);

// ----- test/int32_text_number_parser_top_tb.sv -----
// self-checking testbench of the text number parser: byte stream in, token results out
module int32_text_number_parser_top_tb import itnp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASES         = 10;
    localparam int PHASE_BYTES    = 80;

    typedef longint unsigned wide_t;
    typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_t;

    class parse_scoreboard;
        typedef struct packed {
            value_t value;
            logic   ok;
        } token_result_t;

        token_result_t predicted_tokens[$];
        value_t        min_bound;
        value_t        max_bound;
        phase_t        phase;
        value_t        accum;
        bit            negative;
        int unsigned   hex_count;
        int unsigned   mismatches;
        int unsigned   tokens_checked;
        int unsigned   tokens_ok;

        function new();
            min_bound      = INT_MIN;
            max_bound      = INT_MAX;
            phase          = PH_IDLE;
            accum          = '0;
            negative       = 1'b0;
            hex_count      = 0;
            mismatches     = 0;
            tokens_checked = 0;
            tokens_ok      = 0;
        endfunction

        function void write_bound(cfg_idx_t idx, value_t data);
            if (idx == REG_MIN_ALLOWED)
                min_bound = data;
            else if (idx == REG_MAX_ALLOWED)
                max_bound = data;
        endfunction

        // false when the next digit overflows the signed range
        function bit dec_step(int unsigned d);
            wide_t lim;
            lim = negative ? wide_t'(64'h8000_0000) : wide_t'(64'h7fff_ffff);
            if (wide_t'(accum) > (lim - d) / 10)
                return 1'b0;
            accum = value_t'(wide_t'(accum) * 10 + d);
            return 1'b1;
        endfunction

        function void finish_token(bit ok, value_t pattern);
            if (ok && ($signed(pattern) < $signed(min_bound) ||
                       $signed(pattern) > $signed(max_bound)))
                ok = 1'b0;
            predicted_tokens.push_back('{value: ok ? pattern : '0, ok: ok});
            phase     = PH_IDLE;
            accum     = '0;
            negative  = 1'b0;
            hex_count = 0;
        endfunction

        function void note_char(char_t c);
            bit        delim;
            bit        good;
            logic [3:0] nib;
            delim = c inside {CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF};
            case (phase)
                PH_ZERO:
                    if (delim)
                        finish_token(1'b1, '0);
                    else if (c == CH_LX || c == CH_UX) begin
                        phase     = PH_HEX;
                        accum     = '0;
                        hex_count = 0;
                    end
                    else if (c inside {[CH_0:CH_9]})
                        phase = dec_step(c - CH_0) ? PH_DEC : PH_SKIP;
                    else
                        phase = PH_SKIP;
                PH_DEC:
                    if (delim)
                        finish_token(1'b1, negative ? value_t'(-accum) : accum);
                    else if (!(c inside {[CH_0:CH_9]}) || !dec_step(c - CH_0))
                        phase = PH_SKIP;
                PH_HEX:
                    if (delim)
                        finish_token(1'b1, accum);
                    else begin
                        good = 1'b1;
                        nib  = '0;
                        if (c inside {[CH_0:CH_9]})
                            nib = c - CH_0;
                        else if (c inside {[CH_LA:CH_LF_HEX]})
                            nib = c - CH_LA + 10;
                        else if (c inside {[CH_UA:CH_UF]})
                            nib = c - CH_UA + 10;
                        else
                            good = 1'b0;
                        if (!good)
                            phase = PH_SKIP;
                        else begin
                            accum = (accum << 4) | value_t'(nib);
                            hex_count++;
                            if (hex_count > HEX_DIGITS)
                                phase = PH_SKIP;
                        end
                    end
                PH_SKIP:
                    if (delim)
                        finish_token(1'b0, '0);
                default:
                    // a nul while idle closes an empty token
                    if (c == CH_NUL)
                        finish_token(1'b1, '0);
                    else if (!delim) begin
                        accum     = '0;
                        negative  = 1'b0;
                        hex_count = 0;
                        if (c == CH_0)
                            phase = PH_ZERO;
                        else if (c == CH_MINUS) begin
                            negative = 1'b1;
                            phase    = PH_DEC;
                        end
                        else if (c inside {[CH_1:CH_9]})
                            phase = dec_step(c - CH_0) ? PH_DEC : PH_SKIP;
                        else
                            phase = PH_SKIP;
                    end
            endcase
        endfunction

        function void check_result(value_t value, logic valid_res);
            token_result_t exp_tok;
            if (predicted_tokens.size() == 0) begin
                $display("%0t: unexpected result, actual value %0d valid_res %b",
                         $time, $signed(value), valid_res);
                mismatches++;
                return;
            end
            exp_tok = predicted_tokens.pop_front();
            tokens_checked++;
            if (exp_tok.ok)
                tokens_ok++;
            if (value !== exp_tok.value) begin
                $display("%0t: value mismatch, expected %0d (%h) actual %0d (%h)", $time,
                         $signed(exp_tok.value), exp_tok.value, $signed(value), value);
                mismatches++;
            end
            if (valid_res !== exp_tok.ok) begin
                $display("%0t: valid_res mismatch, expected %b actual %b",
                         $time, exp_tok.ok, valid_res);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    itnp_char_if   text_ch();
    itnp_result_if result_ch();
    itnp_cfg_if    cfg_ch();

    int32_text_number_parser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    parse_scoreboard sb = new();

    rx_mode_t    rx_mode = RX_STEADY;
    bit          gaps_on = 1'b0;
    int unsigned burst_left = 0;
    int unsigned chars_sent = 0;
    int unsigned bound_writes = 0;
    int unsigned idle_cycles = 0;

    char_t delim_set[5] = '{CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF};
    string edge_numbers[5] = '{"2147483647", "2147483648", "-2147483648",
                               "-2147483649", "4294967295"};

    always #(CLK_PERIOD / 2) clk = ~clk;

    // monitors, predictor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_bound(cfg_ch.index, cfg_ch.data);
                bound_writes++;
            end
            if (text_ch.valid && text_ch.ready)
                sb.note_char(text_ch.ch);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.value, result_ch.valid_res);
            if ((cfg_ch.valid && cfg_ch.ready) || (text_ch.valid && text_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result receiver
    initial begin : receiver
        int unsigned tick;
        int unsigned hold_left;
        int unsigned run_left;
        tick            = 0;
        hold_left       = 0;
        run_left        = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            tick++;
            case (rx_mode)
                RX_STEADY:
                    result_ch.ready <= 1'b1;
                RX_RANDOM:
                    result_ch.ready <= ($urandom_range(0, 2) != 0);
                RX_PATTERN:
                    result_ch.ready <= ((tick % 7) inside {0, 1, 4});
                default:
                    // long hold-offs so the parser backs up onto the text side
                    if (run_left != 0) begin
                        result_ch.ready <= 1'b1;
                        run_left--;
                    end
                    else if (hold_left != 0) begin
                        result_ch.ready <= 1'b0;
                        hold_left--;
                        if (hold_left == 0)
                            run_left = $urandom_range(5, 20);
                    end
                    else begin
                        result_ch.ready <= 1'b0;
                        hold_left = $urandom_range(50, 80);
                    end
            endcase
        end
    end

    task automatic send_char(input char_t c);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = gaps_on ? $urandom_range(1, 12) : 64;
            gap        = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        text_ch.valid <= 1'b1;
        text_ch.ch    <= c;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input value_t data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every token result is back
    task automatic settle();
        text_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.predicted_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void push_text(ref char_t t[$], input string s);
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
    endfunction

    function automatic char_t hex_char(int unsigned d);
        if (d < 10)
            return char_t'(CH_0 + d);
        return char_t'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
    endfunction

    function automatic char_t random_byte();
        char_t b;
        do
            b = $urandom_range(0, 1) ? $urandom_range(128, 255) : $urandom_range(1, 127);
        while (b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF});
        return b;
    endfunction

    function automatic void build_token(ref char_t t[$]);
        int unsigned kind;
        int unsigned n;
        int unsigned start;
        longint      lo;
        longint      hi;
        longint      v;
        wide_t       span;
        bit          empty;
        empty = 1'b0;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) t.push_back(delim_set[$urandom_range(1, 4)]);
        start = t.size();
        kind  = $urandom_range(0, 99);
        lo    = $signed(sb.min_bound);
        hi    = $signed(sb.max_bound);
        if (kind < 35) begin
            if (lo > hi) begin
                lo = -50;
                hi = 50;
            end
            case ($urandom_range(0, 5))
                0: v = lo;
                1: v = hi;
                2: v = (lo < hi) ? lo + 1 : lo;
                3: v = (lo < hi) ? hi - 1 : hi;
                default: begin
                    span = wide_t'(hi - lo) + 1;
                    v    = lo + longint'(wide_t'($urandom) % span);
                end
            endcase
            if ($urandom_range(0, 3) == 0) begin
                push_text(t, v < 0 ? "-00" : "00");
                push_text(t, $sformatf("%0d", v < 0 ? -v : v));
            end
            else
                push_text(t, $sformatf("%0d", v));
        end
        else if (kind < 50) begin
            if ($urandom_range(0, 2) == 0)
                push_text(t, edge_numbers[$urandom_range(0, 4)]);
            else begin
                if ($urandom_range(0, 1))
                    t.push_back(CH_MINUS);
                n = $urandom_range(1, 11);
                repeat (n) t.push_back(char_t'(CH_0 + $urandom_range(0, 9)));
            end
        end
        else if (kind < 70) begin
            t.push_back(CH_0);
            t.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 8);
            repeat (n) t.push_back(hex_char($urandom_range(0, 15)));
        end
        else if (kind < 85) begin
            if ($urandom_range(0, 1))
                push_text(t, "0x");
            n = $urandom_range(1, 6);
            repeat (n) t.push_back(hex_char($urandom_range(0, 15)));
            t[$urandom_range(start, t.size() - 1)] = random_byte();
        end
        else if ($urandom_range(0, 2) == 0)
            empty = 1'b1;
        else begin
            n = $urandom_range(1, 4);
            repeat (n) t.push_back(random_byte());
        end
        t.push_back(empty ? CH_NUL : delim_set[$urandom_range(0, 4)]);
    endfunction

    task automatic random_text(input int unsigned n);
        int unsigned start;
        char_t       tok[$];
        start = chars_sent;
        while (chars_sent - start < n) begin
            tok.delete();
            build_token(tok);
            foreach (tok[i])
                send_char(tok[i]);
        end
    endtask

    initial begin
        string  dir_body[$];
        char_t  dir_end[$];
        value_t lo_b;
        value_t hi_b;
        value_t tmp;
        dir_body = '{" \t\015\n2147483647", "-2147483648", "2147483648", "-2147483649",
                     "0xFFFFFFFF", "0X80000000", "0xaBcDeF09", "0x123456789", "0x", "-",
                     "0120", "1-2", "-0x5", "12a4", "0g", "0", "", "-0", "7\377", "0xAf",
                     "00x1", "0x0000000a"};
        dir_end  = '{CH_SPACE, CH_LF, CH_TAB, CH_CR, CH_SPACE, CH_SPACE, CH_NUL, CH_SPACE,
                     CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE,
                     CH_NUL, CH_NUL, CH_TAB, CH_SPACE, CH_LF, CH_SPACE, CH_NUL};
        rst_n         = 1'b0;
        text_ch.valid = 1'b0;
        text_ch.ch    = CH_NUL;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_MIN_ALLOWED;
        cfg_ch.data   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed tokens under the reset bounds
        foreach (dir_body[i]) begin
            for (int k = 0; k < dir_body[i].len(); k++)
                send_char(dir_body[i][k]);
            send_char(dir_end[i]);
        end
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin lo_b = INT_MIN;          hi_b = INT_MAX;        end
                1: begin lo_b = '0;               hi_b = '0;             end
                2: begin lo_b = INT_MAX;          hi_b = INT_MAX;        end
                3: begin lo_b = INT_MIN;          hi_b = INT_MIN;        end
                4: begin lo_b = value_t'(-1000);  hi_b = value_t'(1000); end
                5: begin lo_b = value_t'(100);    hi_b = value_t'(-100); end
                7: begin lo_b = INT_MIN;          hi_b = value_t'(-1);   end
                8: begin lo_b = '0;               hi_b = INT_MAX;        end
                6: begin
                    lo_b = $urandom;
                    hi_b = $urandom;
                    if ($signed(lo_b) > $signed(hi_b)) begin
                        tmp  = lo_b;
                        lo_b = hi_b;
                        hi_b = tmp;
                    end
                end
                default: begin
                    lo_b = $urandom;
                    hi_b = $urandom;
                end
            endcase
            write_reg(REG_MIN_ALLOWED, lo_b);
            write_reg(REG_MAX_ALLOWED, hi_b);
            cfg_ch.valid <= 1'b0;
            @(posedge clk);
            rx_mode = rx_mode_t'(p % 4);
            gaps_on = (p % 4 == 1) || (p % 4 == 2) || (p == 8);
            random_text(PHASE_BYTES);
            rx_mode = RX_STEADY;
            settle();
        end

        $display("run covered %0d text bytes and %0d bound writes over %0d bound settings",
                 chars_sent, bound_writes, PHASES + 1);
        $display("%0d tokens checked, %0d of them parsed and in range",
                 sb.tokens_checked, sb.tokens_ok);
        if (sb.mismatches == 0 && sb.predicted_tokens.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
